/* hw/rtl/kwsc_pkg.sv */
// Package for the keyword substitution cipher engine.
// Holds request codes, alphabet constants, the table port structs and the letter decoder.
// No dependencies.
`timescale 1ns / 1ps

package kwsc_pkg;

    localparam int IDX_W = 5;
    localparam int ALPHA_SIZE = 26;
    localparam logic [IDX_W-1:0] ALPHA_CNT = IDX_W'(ALPHA_SIZE);
    localparam logic [IDX_W-1:0] ALPHA_LAST = IDX_W'(ALPHA_SIZE - 1);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [2:0] REQ_CLEAR   = 3'd0;
    localparam logic [2:0] REQ_KEY     = 3'd1;
    localparam logic [2:0] REQ_FINISH  = 3'd2;
    localparam logic [2:0] REQ_ENCRYPT = 3'd3;
    localparam logic [2:0] REQ_DECRYPT = 3'd4;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] letter;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic             inverse;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

    // Folded letter index 0..25, or the alphabet size for a non-letter.
    function automatic logic [IDX_W-1:0] letter_index(input logic [7:0] b);
        logic [IDX_W-1:0] idx;
        idx = ALPHA_CNT;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
        begin
            idx = IDX_W'(b - CH_UPPER_A);
        end
        else if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
        begin
            idx = IDX_W'(b - CH_LOWER_A);
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/keyword_substitution_cipher_top.sv */
// Top level of the keyword substitution cipher engine: sequencer, letter placement unit
// and output register. Depends on kwsc_pkg and kwsc_tables.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     req_type, data_byte
//   out      output     out_valid / out_ready   out_byte, status, letters_placed
//
// A clear item goes straight to the result step, a key byte via the placement step, and
// encrypt or decrypt via the table lookup step when needed; a finish item visits all 26 letters in turn.
// The block takes one item at a time; in_ready is high only while the sequencer is idle.
// A stalled output holds the sequencer in its result step until the register is free.
// Reset clears the used letters, fill count and ready flag; the tables need no clearing.
`timescale 1ns / 1ps

module keyword_substitution_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        status,
    output logic [4:0]  letters_placed
);
    import kwsc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PLACE, S_LOOK, S_RESULT} state_t;

    state_t                 state_reg;
    logic [2:0]             req_reg;
    logic [7:0]             byte_reg;
    logic [IDX_W-1:0]       cand_reg;
    logic                   walk_reg;
    logic [ALPHA_SIZE-1:0]  used_reg;
    logic [IDX_W-1:0]       fill_reg;
    logic                   ready_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   status_reg;
    logic [IDX_W-1:0]       placed_reg;

    tbl_wr_t                tbl_wr;
    tbl_rd_t                tbl_rd;
    logic [IDX_W-1:0]       rd_data;
    logic                   cand_used;
    logic                   place_ok;
    logic [IDX_W-1:0]       item_idx;
    logic [IDX_W-1:0]       in_idx;
    logic [IDX_W-1:0]       cipher_idx;
    logic                   is_xlate;
    logic [7:0]             res_byte;
    logic                   res_status;
    logic                   out_load;

    kwsc_tables u_tables (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (rd_data)
    );

    assign in_idx   = letter_index(data_byte);
    assign item_idx = letter_index(byte_reg);

    // The shared placement unit checks one candidate letter per cycle and appends it if unused.
    always_comb
    begin
        cand_used = 1'b1;
        if (cand_reg < ALPHA_CNT)
        begin
            cand_used = used_reg[cand_reg];
        end
        place_ok = (cand_reg < ALPHA_CNT) && (fill_reg < ALPHA_CNT) && !cand_used;
    end

    assign tbl_wr.en      = (state_reg == S_PLACE) && place_ok;
    assign tbl_wr.pos     = fill_reg;
    assign tbl_wr.letter  = cand_reg;
    assign tbl_rd.en      = (state_reg == S_LOOK);
    assign tbl_rd.inverse = (req_reg == REQ_DECRYPT);
    assign tbl_rd.addr    = item_idx;

    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        is_xlate   = (req_reg == REQ_ENCRYPT) || (req_reg == REQ_DECRYPT);
        cipher_idx = (rd_data < ALPHA_CNT) ? rd_data : '0;
        res_byte   = '0;
        res_status = 1'b0;
        if (is_xlate)
        begin
            if (!ready_reg)
            begin
                res_byte   = byte_reg;
                res_status = 1'b1;
            end
            else if (item_idx < ALPHA_CNT)
            begin
                res_byte = CH_LOWER_A + {3'b000, cipher_idx};
            end
            else
            begin
                res_byte = byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= REQ_CLEAR;
            byte_reg      <= '0;
            cand_reg      <= '0;
            walk_reg      <= 1'b0;
            used_reg      <= '0;
            fill_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            status_reg    <= 1'b0;
            placed_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg  <= req_type;
                        byte_reg <= data_byte;
                        case (req_type)
                            REQ_CLEAR:
                            begin
                                used_reg  <= '0;
                                fill_reg  <= '0;
                                ready_reg <= 1'b0;
                                state_reg <= S_RESULT;
                            end
                            REQ_KEY:
                            begin
                                cand_reg  <= in_idx;
                                walk_reg  <= 1'b0;
                                state_reg <= S_PLACE;
                            end
                            REQ_FINISH:
                            begin
                                cand_reg  <= '0;
                                walk_reg  <= 1'b1;
                                state_reg <= S_PLACE;
                            end
                            REQ_ENCRYPT, REQ_DECRYPT:
                            begin
                                if (ready_reg && (in_idx < ALPHA_CNT))
                                begin
                                    state_reg <= S_LOOK;
                                end
                                else
                                begin
                                    state_reg <= S_RESULT;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_PLACE:
                begin
                    if (place_ok)
                    begin
                        used_reg <= used_reg | ({{(ALPHA_SIZE-1){1'b0}}, 1'b1} << cand_reg);
                        fill_reg <= fill_reg + IDX_W'(1);
                    end
                    if (!walk_reg || (cand_reg == ALPHA_LAST))
                    begin
                        if (walk_reg)
                        begin
                            ready_reg <= 1'b1;
                        end
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        cand_reg <= cand_reg + IDX_W'(1);
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_load)
                    begin
                        out_byte_reg  <= res_byte;
                        status_reg    <= res_status;
                        placed_reg    <= fill_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign status         = status_reg;
    assign letters_placed = placed_reg;

    // The fill count always equals the number of letters marked as used.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(fill_reg))
        else $error("Fill count disagrees with the used letter set.");

    // The fill count never passes the alphabet size.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ALPHA_CNT)
        else $error("Fill count beyond alphabet size.");

    // A finished alphabet holds every letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (fill_reg == ALPHA_CNT))
        else $error("Alphabet marked ready while not full.");

    // A table read happens only for a translate item on a finished alphabet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> (ready_reg && (item_idx < ALPHA_CNT)))
        else $error("Table lookup without a finished alphabet.");

endmodule

/* hw/rtl/kwsc_tables.sv */
// Forward and inverse cipher tables with one write port and one registered read port.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps

module kwsc_tables (
    input  logic                            clk,
    input  kwsc_pkg::tbl_wr_t               wr,
    input  kwsc_pkg::tbl_rd_t               rd,
    output logic [kwsc_pkg::IDX_W-1:0]      rd_data
);
    import kwsc_pkg::*;

    logic [IDX_W-1:0] fwd_mem [ALPHA_SIZE];
    logic [IDX_W-1:0] inv_mem [ALPHA_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fwd_mem[wr.pos]    <= wr.letter;
            inv_mem[wr.letter] <= wr.pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            if (rd.inverse)
            begin
                rd_data <= inv_mem[rd.addr];
            end
            else
            begin
                rd_data <= fwd_mem[rd.addr];
            end
        end
    end

endmodule
